FILE: rtl/core/cdq_pkg.sv
// Shared types for the circular deque: opcodes, status codes, controller/datapath links.
`timescale 1ns / 1ps
package cdq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_READ_ALL   = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic    capture;
		logic    push;
		logic    pop;
		logic    walk_load;
		logic    walk_step;
		logic    emit;
		status_t emit_status;
		logic    emit_data;
		logic    emit_last;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    empty;
		logic    walk_at_tail;
		logic    out_free;
	} sts_t;

endpackage

FILE: rtl/core/circular_deque_unit.sv
// Circular double-ended queue of signed 32-bit words: top level.
//
// Input channel (in_valid/in_ready, opcode, value) takes one command per
// transfer: push front, push rear, pop front, pop rear or read all. Output
// channel (out_valid/out_ready, status, data, last, full_res, empty_res)
// returns the results; last marks the final result of each command.
// One command is worked on at a time. Push: the command is captured, then its
// result is registered in the output register. Pop: the registered store
// read lies between the two. Read all: the first result as for a pop, then
// one element per cycle from front to rear while the receiver does not stall.
// The next command is taken once the last result sits in the output register.
// Opcodes 5 to 7 give no result.
// When the receiver stalls, the output register holds its result and the
// controller waits; no result is dropped or repeated.
// Reset empties the deque at once (indices to 0, empty set); the store
// holds no reset value and needs no clearing pass.
`timescale 1ns / 1ps
module circular_deque_unit #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] data,
	output logic               last,
	output logic               full_res,
	output logic               empty_res
);
	import cdq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cdq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.opcode   (opcode),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.data     (data),
		.last     (last),
		.full_res (full_res),
		.empty_res(empty_res)
	);

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(full_res && empty_res))
		else $error("full and empty reported together");

	a_reject_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (last && (data == 32'sd0)))
		else $error("rejected command gave more than one result or nonzero data");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second command taken while one is in progress");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.full)
		else $error("store written while full");

endmodule

FILE: rtl/core/cdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/cdq_dp.sv
// Deque datapath: indices, empty flag, store, list walker and result register.
`timescale 1ns / 1ps
module cdq_dp #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cdq_pkg::cmd_t       cmd,
	output cdq_pkg::sts_t       sts,
	input  logic [2:0]          opcode,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic signed [31:0]  data,
	output logic                last,
	output logic                full_res,
	output logic                empty_res
);
	import cdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	opcode_t            op_q;
	logic signed [31:0] val_q;
	logic [AW-1:0]      head_q, tail_q, walk_q;
	logic               empty_q;
	logic [AW-1:0]      head_d, tail_d;
	logic               empty_d, full_d, full_now, front;
	logic               we, re;
	logic [AW-1:0]      waddr, raddr;
	logic [31:0]        rdata;
	logic               out_valid_q, last_q, full_res_q, empty_res_q;
	status_t            status_q;
	logic signed [31:0] data_q;

	assign front    = (op_q == OP_PUSH_FRONT) || (op_q == OP_POP_FRONT);
	assign full_now = !empty_q && (idx_next(tail_q) == head_q);

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		empty_d = empty_q;
		waddr   = '0;
		if (cmd.push) begin
			if (empty_q) begin
				head_d  = '0;
				tail_d  = '0;
				empty_d = 1'b0;
			end else if (front) begin
				head_d = idx_prev(head_q);
				waddr  = head_d;
			end else begin
				tail_d = idx_next(tail_q);
				waddr  = tail_d;
			end
		end else if (cmd.pop) begin
			if (head_q == tail_q) begin
				head_d  = '0;
				tail_d  = '0;
				empty_d = 1'b1;
			end else if (front) begin
				head_d = idx_next(head_q);
			end else begin
				tail_d = idx_prev(tail_q);
			end
		end
		full_d = !empty_d && (idx_next(tail_d) == head_d);
	end

	assign we = cmd.push;
	assign re = cmd.pop || cmd.walk_load || cmd.walk_step;

	always_comb begin
		if (cmd.pop) begin
			raddr = front ? head_q : tail_q;
		end else if (cmd.walk_load) begin
			raddr = head_q;
		end else begin
			raddr = idx_next(walk_q);
		end
	end

	cdq_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(val_q),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode_t'(opcode);
			val_q <= value;
		end
		if (cmd.walk_load) begin
			walk_q <= head_q;
		end else if (cmd.walk_step) begin
			walk_q <= raddr;
		end
		if (cmd.emit) begin
			status_q    <= cmd.emit_status;
			data_q      <= cmd.emit_data ? signed'(rdata) : 32'sd0;
			last_q      <= cmd.emit_last;
			full_res_q  <= full_d;
			empty_res_q <= empty_d;
		end
	end

	assign sts.op           = op_q;
	assign sts.full         = full_now;
	assign sts.empty        = empty_q;
	assign sts.walk_at_tail = (walk_q == tail_q);
	assign sts.out_free     = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign last      = last_q;
	assign full_res  = full_res_q;
	assign empty_res = empty_res_q;

endmodule

FILE: rtl/core/cdq_ctrl.sv
// Deque controller: sequences one transfer at a time through execute, pop and list states.
`timescale 1ns / 1ps
module cdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cdq_pkg::sts_t sts,
	output cdq_pkg::cmd_t cmd
);
	import cdq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP_OUT,
		S_LIST
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.emit_status = ST_OK;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					case (sts.op)
						OP_PUSH_FRONT, OP_PUSH_REAR: begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.push        = !sts.full;
							cmd.emit_status = sts.full ? ST_FULL : ST_OK;
							state_d         = S_IDLE;
						end
						OP_POP_FRONT, OP_POP_REAR: begin
							if (sts.empty) begin
								cmd.emit        = 1'b1;
								cmd.emit_last   = 1'b1;
								cmd.emit_status = ST_EMPTY;
								state_d         = S_IDLE;
							end else begin
								cmd.pop = 1'b1;
								state_d = S_POP_OUT;
							end
						end
						OP_READ_ALL: begin
							if (sts.empty) begin
								cmd.emit      = 1'b1;
								cmd.emit_last = 1'b1;
								state_d       = S_IDLE;
							end else begin
								cmd.walk_load = 1'b1;
								state_d       = S_LIST;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_POP_OUT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_data = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_LIST: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_data = 1'b1;
					cmd.emit_last = sts.walk_at_tail;
					if (sts.walk_at_tail) begin
						state_d = S_IDLE;
					end else begin
						cmd.walk_step = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: tb/circular_deque_checker.sv
// Deque result checker: tracks accepted commands, predicts every result and compares.
`timescale 1ns / 1ps
module circular_deque_checker #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic signed [31:0] data,
	input  logic               last,
	input  logic               full_res,
	input  logic               empty_res,
	output int                 fail_count,
	output int                 pending_results
);
	import cdq_pkg::*;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] data;
		logic               last;
		logic               full;
		logic               empty;
	} deque_result_t;

	logic signed [31:0] words [DEPTH];
	int                 head_idx;
	int                 tail_idx;
	logic               deque_empty;
	int                 failures = 0;
	deque_result_t      expected_results [$];

	function automatic logic deque_full();
		return !deque_empty && ((tail_idx + 1) % DEPTH) == head_idx;
	endfunction

	function automatic void add_result(input status_t st, input logic signed [31:0] d,
			input logic fin);
		deque_result_t r;
		r.status = st;
		r.data   = d;
		r.last   = fin;
		r.full   = deque_full();
		r.empty  = deque_empty;
		expected_results.push_back(r);
	endfunction

	function automatic void apply_command(input logic [2:0] op, input logic signed [31:0] val);
		int                 walk;
		int                 n;
		logic signed [31:0] word;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (deque_full()) begin
					add_result(ST_FULL, '0, 1'b1);
				end else begin
					if (deque_empty) begin
						head_idx    = 0;
						tail_idx    = 0;
						deque_empty = 1'b0;
						words[0]    = val;
					end else if (op == OP_PUSH_FRONT) begin
						head_idx        = (head_idx + DEPTH - 1) % DEPTH;
						words[head_idx] = val;
					end else begin
						tail_idx        = (tail_idx + 1) % DEPTH;
						words[tail_idx] = val;
					end
					add_result(ST_OK, '0, 1'b1);
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (deque_empty) begin
					add_result(ST_EMPTY, '0, 1'b1);
				end else begin
					word = (op == OP_POP_FRONT) ? words[head_idx] : words[tail_idx];
					if (head_idx == tail_idx) begin
						head_idx    = 0;
						tail_idx    = 0;
						deque_empty = 1'b1;
					end else if (op == OP_POP_FRONT) begin
						head_idx = (head_idx + 1) % DEPTH;
					end else begin
						tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
					end
					add_result(ST_OK, word, 1'b1);
				end
			end
			OP_READ_ALL: begin
				if (deque_empty) begin
					add_result(ST_OK, '0, 1'b1);
				end else begin
					walk = head_idx;
					for (n = 0; n < DEPTH; n++) begin
						add_result(ST_OK, words[walk], walk == tail_idx || n == DEPTH - 1);
						if (walk == tail_idx)
							break;
						walk = (walk + 1) % DEPTH;
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic compare_field(input string field, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			head_idx    = 0;
			tail_idx    = 0;
			deque_empty = 1'b1;
			expected_results.delete();
			pending_results <= 0;
			fail_count      <= 0;
		end else begin
			if (in_valid && in_ready)
				apply_command(opcode, value);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					failures++;
					$display("%0t: result with none expected, expected nothing, got status %0d data %0d",
						$time, status, data);
				end else begin
					want = expected_results.pop_front();
					compare_field("status", 32'(want.status), 32'(status));
					compare_field("data", want.data, data);
					compare_field("last", 32'(want.last), 32'(last));
					compare_field("full_res", 32'(want.full), 32'(full_res));
					compare_field("empty_res", 32'(want.empty), 32'(empty_res));
				end
			end
			pending_results <= expected_results.size();
			fail_count      <= failures;
		end
	end

endmodule

FILE: tb/circular_deque_unit_tb.sv
// Testbench top for the circular deque: clock, reset, command and result stimulus, verdict.
`timescale 1ns / 1ps
module circular_deque_unit_tb;
	import cdq_pkg::*;

	localparam int         DEPTH         = 16;
	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         RANDOM_ITEMS  = 65;
	localparam int         HOLD_CYCLES   = 160;
	localparam int         TAIL_CYCLES   = 20;
	localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [2:0]         opcode    = OP_PUSH_FRONT;
	logic signed [31:0] value     = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] data;
	logic               last;
	logic               full_res;
	logic               empty_res;
	int                 fail_count;
	int                 pending_results;
	int                 cycle_count   = 0;
	bit                 sender_gaps   = 1'b1;
	bit                 receiver_gaps = 1'b1;
	bit                 hold_request  = 1'b0;

	circular_deque_unit #(.DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .data(data),
		.last(last), .full_res(full_res), .empty_res(empty_res)
	);

	circular_deque_checker #(.DEPTH(DEPTH)) deque_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .data(data),
		.last(last), .full_res(full_res), .empty_res(empty_res),
		.fail_count(fail_count), .pending_results(pending_results)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		bit held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request && !held) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else begin
				out_ready <= !receiver_gaps || ($urandom_range(0, 99) >= 33);
				@(posedge clk);
			end
		end
	end

	function automatic logic signed [31:0] random_word();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] random_push();
		return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
	endfunction

	function automatic logic [2:0] random_pop();
		return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
	endfunction

	task automatic send_item(input logic [2:0] op, input logic signed [31:0] val);
		if (sender_gaps && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < 33) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		value    <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	initial begin
		int         i;
		int         roll;
		int         push_bias;
		logic [2:0] op;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_POP_FRONT, '0);
		send_item(OP_POP_REAR, -32'sd1);
		send_item(OP_READ_ALL, '0);
		send_item(OP_PUSH_FRONT, 32'sh8000_0000);
		send_item(OP_POP_REAR, '0);
		send_item(OP_PUSH_REAR, 32'sh7fff_ffff);
		send_item(OP_PUSH_FRONT, -32'sd1);
		send_item(OP_PUSH_REAR, '0);
		send_item(OP_PUSH_FRONT, 32'sh5555_5555);
		send_item(OP_PUSH_REAR, 32'shaaaa_aaaa);
		send_item(OP_READ_ALL, '0);
		send_item(OP_UNUSED_LO, 32'sh1234_5678);
		send_item(OP_UNUSED_MID, '0);
		send_item(OP_UNUSED_HI, -32'sd1);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_POP_REAR, '0);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_POP_REAR, '0);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_POP_REAR, '0);
		send_item(OP_READ_ALL, '0);

		// stall the result side while commands keep coming, then let it drain
		hold_request = 1'b1;
		for (i = 0; i < 6; i++)
			send_item(random_push(), random_word());
		send_item(OP_READ_ALL, '0);
		wait_drained();

		// fill past full and drain past empty back to back
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		for (i = 0; i < DEPTH + 1; i++)
			send_item(random_push(), random_word());
		send_item(OP_READ_ALL, '0);
		send_item(random_push(), random_word());
		for (i = 0; i < DEPTH + 1; i++)
			send_item(random_pop(), random_word());
		send_item(OP_READ_ALL, '0);
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			case ((i / 16) % 3)
				0:       push_bias = 80;
				1:       push_bias = 25;
				default: push_bias = 50;
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 4)
				op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			else if (roll < 12)
				op = OP_READ_ALL;
			else if ($urandom_range(0, 99) < push_bias)
				op = random_push();
			else
				op = random_pop();
			send_item(op, random_word());
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
